FILE: src/lsb_pkg.sv
// Shared types, codes and helper functions for the link supervisor.
// No dependencies; every other file but lsb_if imports this package.
package lsb_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 2'd3;

    // Event commands
    localparam logic [2:0] CMD_CONNECT     = 3'd0;
    localparam logic [2:0] CMD_DISCONNECT  = 3'd1;
    localparam logic [2:0] CMD_XPORT_ERROR = 3'd2;
    localparam logic [2:0] CMD_XPORT_DROP  = 3'd3;
    localparam logic [2:0] CMD_KEEPALIVE   = 3'd4;
    localparam logic [2:0] CMD_PROBE_TMO   = 3'd5;
    localparam logic [2:0] CMD_RETRY_EXP   = 3'd6;
    localparam logic [2:0] CMD_RESPONSE    = 3'd7;

    // Link states
    localparam logic [1:0] ST_DISCONNECTED = 2'd0;
    localparam logic [1:0] ST_CONNECTING   = 2'd1;
    localparam logic [1:0] ST_CONNECTED    = 2'd2;
    localparam logic [1:0] ST_RECONNECTING = 2'd3;

    // Notices
    localparam logic [1:0] NOTE_NONE         = 2'd0;
    localparam logic [1:0] NOTE_CONNECTED    = 2'd1;
    localparam logic [1:0] NOTE_DISCONNECTED = 2'd2;
    localparam logic [1:0] NOTE_LOST         = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_OPEN_FAILED = 3'd1;
    localparam logic [2:0] ERR_XPORT       = 3'd2;
    localparam logic [2:0] ERR_PROBE_TMO   = 3'd3;
    localparam logic [2:0] ERR_EXHAUSTED   = 3'd4;

    localparam logic [14:0] DELAY_CAP_MS = 15'd30000;
    localparam logic [3:0]  SHIFT_CAP    = 4'd10;

    typedef struct packed {
        logic [7:0]  max_retries;
        logic [14:0] base_retry_delay_ms;
        logic [15:0] probe_timeout_ms;
        logic [19:0] silence_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  command;
        logic        open_ok;
        logic        is_info_reply;
        logic [31:0] time_ms;
    } evt_t;

    typedef struct packed {
        logic [1:0]  link_state;
        logic        stop_timers;
        logic        start_probe_timer;
        logic        start_retry_timer;
        logic [14:0] retry_delay_ms;
        logic        start_keepalive;
        logic        send_probe;
        logic        send_keepalive;
        logic [1:0]  notice;
        logic [2:0]  error_code;
        logic [7:0]  attempt_number;
    } res_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  attempts;
        logic [31:0] last_reply_ms;
    } lsb_state_t;

    // base << min(n, 10), saturated at the cap
    function automatic logic [14:0] backoff(input logic [14:0] base, input logic [7:0] n);
        logic [3:0]  sh;
        logic [24:0] d;
        sh = (n < 8'(SHIFT_CAP)) ? n[3:0] : SHIFT_CAP;
        d  = {10'd0, base} << sh;
        return (d > {10'd0, DELAY_CAP_MS}) ? DELAY_CAP_MS : d[14:0];
    endfunction

endpackage

FILE: src/lsb_if.sv
// Valid/ready channel interfaces for events, results and configuration.
// Has no dependencies; its field widths match those of the lsb_pkg types.
interface lsb_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic        open_ok;
    logic        is_info_reply;
    logic [31:0] time_ms;

    modport source (output valid, command, open_ok, is_info_reply, time_ms, input ready);
    modport sink   (input valid, command, open_ok, is_info_reply, time_ms, output ready);
endinterface

interface lsb_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  link_state;
    logic        stop_timers;
    logic        start_probe_timer;
    logic        start_retry_timer;
    logic [14:0] retry_delay_ms;
    logic        start_keepalive;
    logic        send_probe;
    logic        send_keepalive;
    logic [1:0]  notice;
    logic [2:0]  error_code;
    logic [7:0]  attempt_number;

    modport source (output valid, link_state, stop_timers, start_probe_timer,
                    start_retry_timer, retry_delay_ms, start_keepalive, send_probe,
                    send_keepalive, notice, error_code, attempt_number, input ready);
    modport sink   (input valid, link_state, stop_timers, start_probe_timer,
                    start_retry_timer, retry_delay_ms, start_keepalive, send_probe,
                    send_keepalive, notice, error_code, attempt_number, output ready);
endinterface

interface lsb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/lsb_cfg_regs.sv
// Configuration register file for the link supervisor.
// Depends on lsb_pkg and the lsb_cfg_if interface.
module lsb_cfg_regs
    import lsb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lsb_cfg_if.sink   cfg,
    output cfg_t      cfg_q
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MAX_RETRIES:   cfg_next.max_retries         = cfg.data[7:0];
                REG_BASE_DELAY:    cfg_next.base_retry_delay_ms = cfg.data[14:0];
                REG_PROBE_TIMEOUT: cfg_next.probe_timeout_ms    = cfg.data[15:0];
                REG_SILENCE_LIMIT: cfg_next.silence_limit_ms    = cfg.data[19:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_retries         <= 8'd5;
            cfg_reg.base_retry_delay_ms <= 15'd1000;
            cfg_reg.probe_timeout_ms    <= 16'd3000;
            cfg_reg.silence_limit_ms    <= 20'd10000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/lsb_step.sv
// Next-state and result logic for one supervisor event.
// Depends on lsb_pkg (types, codes, backoff function).
module lsb_step
    import lsb_pkg::*;
(
    input  evt_t       evt,
    input  lsb_state_t cur,
    input  cfg_t       cfg,
    output lsb_state_t nxt,
    output res_t       res
);

    logic        begin_reconn;
    logic        retry_left;
    logic [31:0] age_ms;
    logic [14:0] delay;

    assign retry_left = cur.attempts < cfg.max_retries;
    assign age_ms     = evt.time_ms - cur.last_reply_ms;

    always_comb
    begin
        nxt          = cur;
        res          = '0;
        begin_reconn = 1'b0;
        delay        = backoff(cfg.base_retry_delay_ms, cur.attempts);

        case (evt.command)
            CMD_CONNECT:
            begin
                if (cur.mode == ST_CONNECTING || cur.mode == ST_CONNECTED)
                begin
                    res.stop_timers = 1'b1;
                    res.notice      = NOTE_DISCONNECTED;
                end
                nxt.attempts = 8'd0;
                if (evt.open_ok)
                begin
                    nxt.mode              = ST_CONNECTING;
                    res.send_probe        = 1'b1;
                    res.start_probe_timer = 1'b1;
                end
                else
                begin
                    nxt.mode       = ST_DISCONNECTED;
                    res.error_code = ERR_OPEN_FAILED;
                end
            end
            CMD_DISCONNECT:
            begin
                res.stop_timers = 1'b1;
                res.notice      = NOTE_DISCONNECTED;
                nxt.attempts    = 8'd0;
                nxt.mode        = ST_DISCONNECTED;
            end
            CMD_XPORT_ERROR, CMD_PROBE_TMO:
            begin
                // a probe timeout only reports while connecting or out of retries
                res.error_code = (evt.command == CMD_XPORT_ERROR) ? ERR_XPORT : ERR_NONE;
                if (cur.mode == ST_CONNECTING)
                begin
                    res.error_code = (evt.command == CMD_XPORT_ERROR) ? ERR_XPORT
                                                                      : ERR_PROBE_TMO;
                    begin_reconn   = 1'b1;
                end
                else if (cur.mode == ST_RECONNECTING)
                begin
                    if (!retry_left)
                    begin
                        nxt.mode       = ST_DISCONNECTED;
                        res.error_code = ERR_EXHAUSTED;
                    end
                    else
                    begin
                        res.start_retry_timer = 1'b1;
                        res.retry_delay_ms    = delay;
                    end
                end
            end
            CMD_XPORT_DROP:
            begin
                if (cur.mode == ST_CONNECTED)
                begin
                    res.notice   = NOTE_LOST;
                    begin_reconn = 1'b1;
                end
            end
            CMD_KEEPALIVE:
            begin
                if (cur.mode == ST_CONNECTED)
                begin
                    if (cur.last_reply_ms != 32'd0 && age_ms > {12'd0, cfg.silence_limit_ms})
                    begin
                        res.notice   = NOTE_LOST;
                        begin_reconn = 1'b1;
                    end
                    else
                    begin
                        res.send_keepalive = 1'b1;
                    end
                end
            end
            CMD_RETRY_EXP:
            begin
                if (!retry_left)
                begin
                    nxt.mode       = ST_DISCONNECTED;
                    res.error_code = ERR_EXHAUSTED;
                end
                else
                begin
                    nxt.attempts = cur.attempts + 8'd1;
                    if (!evt.open_ok)
                    begin
                        // delay of the attempt just made
                        res.start_retry_timer = 1'b1;
                        res.retry_delay_ms    = delay;
                        res.error_code        = ERR_OPEN_FAILED;
                    end
                    else
                    begin
                        res.send_probe        = 1'b1;
                        res.start_probe_timer = 1'b1;
                    end
                end
            end
            default:
            begin
                nxt.last_reply_ms = evt.time_ms;
                if (evt.is_info_reply)
                begin
                    if (cur.mode == ST_CONNECTING || cur.mode == ST_RECONNECTING)
                    begin
                        res.stop_timers     = 1'b1;
                        nxt.mode            = ST_CONNECTED;
                        res.start_keepalive = 1'b1;
                        res.send_keepalive  = 1'b1;
                        nxt.attempts        = 8'd0;
                        res.notice          = NOTE_CONNECTED;
                    end
                    else if (cur.mode == ST_DISCONNECTED)
                    begin
                        res.stop_timers = 1'b1;
                    end
                end
            end
        endcase

        if (begin_reconn)
        begin
            res.stop_timers       = 1'b1;
            nxt.mode              = ST_RECONNECTING;
            res.start_retry_timer = 1'b1;
            res.retry_delay_ms    = backoff(cfg.base_retry_delay_ms, 8'd0);
        end

        res.link_state     = nxt.mode;
        res.attempt_number = nxt.attempts;
    end

endmodule

FILE: src/link_supervisor_with_backoff.sv
// Top level of the link supervisor: input register, state, result register.
// Depends on lsb_pkg, lsb_if, lsb_cfg_regs and lsb_step.
//
//  channel  | modport | carries
//  ---------+---------+----------------------------------------------
//  evt      | sink    | command, open_ok, is_info_reply, time_ms
//  res      | source  | new state, timer controls, delay, notices
//  cfg      | sink    | register index and write data
//
// One event per cycle while the result register is not stalled.
// The event is held in an input register, then the step logic updates
// the link state and loads the result register in the same cycle.
// Both registers advance when the result register is empty or being taken,
// so a stalled result holds the event behind it without loss.
// rst_n asynchronously clears the valid flags and link state and loads the configuration defaults.
module link_supervisor_with_backoff
    import lsb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lsb_evt_if.sink   evt,
    lsb_res_if.source res,
    lsb_cfg_if.sink   cfg
);

    cfg_t       cfg_q;
    evt_t       evt_reg;
    logic       in_valid_reg;
    res_t       out_reg;
    logic       out_valid_reg;
    lsb_state_t state_reg;
    lsb_state_t state_next;
    res_t       step_res;
    logic       advance;

    lsb_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    lsb_step u_step (
        .evt (evt_reg),
        .cur (state_reg),
        .cfg (cfg_q),
        .nxt (state_next),
        .res (step_res)
    );

    assign advance   = !out_valid_reg || res.ready;
    assign evt.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (evt.ready)
            begin
                in_valid_reg <= evt.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            evt_reg.command       <= evt.command;
            evt_reg.open_ok       <= evt.open_ok;
            evt_reg.is_info_reply <= evt.is_info_reply;
            evt_reg.time_ms       <= evt.time_ms;
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= step_res;
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.link_state        = out_reg.link_state;
    assign res.stop_timers       = out_reg.stop_timers;
    assign res.start_probe_timer = out_reg.start_probe_timer;
    assign res.start_retry_timer = out_reg.start_retry_timer;
    assign res.retry_delay_ms    = out_reg.retry_delay_ms;
    assign res.start_keepalive   = out_reg.start_keepalive;
    assign res.send_probe        = out_reg.send_probe;
    assign res.send_keepalive    = out_reg.send_keepalive;
    assign res.notice            = out_reg.notice;
    assign res.error_code        = out_reg.error_code;
    assign res.attempt_number    = out_reg.attempt_number;

    a_delay_capped: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.start_retry_timer |-> res.retry_delay_ms <= DELAY_CAP_MS)
        else $error("retry delay above cap");

    a_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.start_retry_timer |-> res.retry_delay_ms == 15'd0)
        else $error("retry delay set without retry timer start");

    a_connected_note: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.notice == NOTE_CONNECTED
        |-> res.link_state == ST_CONNECTED && res.attempt_number == 8'd0)
        else $error("connected notice with inconsistent state");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && in_valid_reg) |=> $stable(state_reg))
        else $error("link state changed without an event");

    a_state_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg |=> out_reg.link_state == state_reg.mode
                                 && out_reg.attempt_number == state_reg.attempts)
        else $error("result does not match stored state");

endmodule
